[hdl/brb_pkg.sv]
// Shared types, constants and helper functions of the byte ring buffer with burst requests.
package brb_pkg;

  // Store geometry and burst limit.
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SUM_W     = CNT_W + 1;

  // Request kinds on the input channel.
  typedef enum logic [1:0] {
    REQ_WR_HDR  = 2'd0,
    REQ_WR_DATA = 2'd1,
    REQ_RD      = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_type_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_REJECT  = 2'd1,
    STS_SEQ_ERR = 2'd2
  } status_e;

  // Operations the controller hands to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_HDR_OK,
    OP_REJECT,
    OP_SEQ_ERR,
    OP_DATA_WR,
    OP_RD_START,
    OP_RD_EMPTY,
    OP_RD_BYTE,
    OP_CLEAR
  } dp_op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_e;

  // One input request.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [LEN_W-1:0]  burst_length;
    logic [BYTE_W-1:0] data_byte;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  bytes_done;
    logic              last;
    logic [CNT_W-1:0]  available;
    logic [CNT_W-1:0]  free_space;
  } out_rsp_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic             pending_zero;
    logic             fill_zero;
    logic [CNT_W-1:0] free_space;
    logic             rd_last;
  } dp_sts_t;

  // Advance a position, wrapping to zero once it reaches the capacity in use.
  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] pos,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(pos) + CNT_W'(1);
    return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
  endfunction

  // Free space, floored at zero when the capacity shrank below the fill.
  function automatic logic [CNT_W-1:0] free_of(input logic [CNT_W-1:0] fill,
                                               input logic [CNT_W-1:0] cap);
    return (fill >= cap) ? '0 : cap - fill;
  endfunction

  // Bring a written capacity into the legal range.
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(DEPTH)) begin
      r = CNT_W'(DEPTH);
    end
    return r;
  endfunction

endpackage

[hdl/byte_ring_buffer_burst.sv]
// Top level of the byte ring buffer with burst writes and clamped burst reads.
// A 256-byte circular FIFO. A write header reserves a burst of 1 to 64 bytes if it fits
// the free space, the data requests that follow are stored one per cycle while the
// output does not stall, and the fill count grows by the whole burst when its last byte
// lands. A read request returns up to 64 bytes, one result per byte, last set on the
// final one. Header, data, clear and rejected requests each give one result. A read
// burst first primes the registered read port of the byte store, then returns one byte
// per cycle from that port while the output does not stall, and no new request is
// taken until the burst is out. The capacity register sits at byte address 0 of the
// APB port; write it only while the block is idle, which the block does not enforce.
module byte_ring_buffer_burst import brb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_req_t     in_req_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output out_rsp_t    out_rsp_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [CNT_W-1:0] cap;
  logic             cfg_we;

  // Register decode: word 0 holds the capacity in use.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, cap};

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[CNT_W-1:0]),
    .cap_o       (cap),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

[hdl/brb_ctrl.sv]
// Controller state machine of the byte ring buffer: request decode and read burst sequencing.
module brb_ctrl import brb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_req_t in_req_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        len_zero;
  logic        len_over;
  logic        len_no_room;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign len_zero    = (in_req_i.burst_length == '0);
  assign len_over    = (in_req_i.burst_length > LEN_W'(MAX_BURST));
  assign len_no_room = (CNT_W'(in_req_i.burst_length) > sts_i.free_space);

  // Next state and datapath command.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '{op: OP_NONE, load_out: 1'b0};
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          cmd_o.load_out = 1'b1;
          case (in_req_i.req_type)
            REQ_WR_HDR: begin
              if (!sts_i.pending_zero) begin
                cmd_o.op = OP_SEQ_ERR;
              end else if (len_zero || len_over || len_no_room) begin
                cmd_o.op = OP_REJECT;
              end else begin
                cmd_o.op = OP_HDR_OK;
              end
            end
            REQ_WR_DATA: begin
              cmd_o.op = sts_i.pending_zero ? OP_SEQ_ERR : OP_DATA_WR;
            end
            REQ_RD: begin
              if (!sts_i.pending_zero) begin
                cmd_o.op = OP_SEQ_ERR;
              end else if (len_zero) begin
                cmd_o.op = OP_REJECT;
              end else if (sts_i.fill_zero) begin
                cmd_o.op = OP_RD_EMPTY;
              end else begin
                // The burst is emitted from the read state, one byte per result.
                cmd_o.op       = OP_RD_START;
                cmd_o.load_out = 1'b0;
                state_d        = ST_READ;
              end
            end
            default: begin
              cmd_o.op = OP_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_o.op       = OP_RD_BYTE;
          cmd_o.load_out = 1'b1;
          if (sts_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  // The output register holds a result until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A held result is never dropped.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("brb_ctrl: stalled result lost");

  // No request is taken while a read burst is being emitted.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> state_q == ST_IDLE)
    else $error("brb_ctrl: request accepted during a read burst");

  // A read burst never runs with a write burst open.
  a_read_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> sts_i.pending_zero)
    else $error("brb_ctrl: read burst with write burst open");

  // The final byte of a burst returns the controller to idle.
  a_read_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ && cmd_o.op == OP_RD_BYTE && sts_i.rd_last |=> state_q == ST_IDLE)
    else $error("brb_ctrl: read burst did not end");
`endif

endmodule

[hdl/brb_datapath.sv]
// Datapath of the byte ring buffer: byte store, positions, counts and the result register.
module brb_datapath import brb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  in_req_t          in_req_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic [CNT_W-1:0] cap_o,
  output dp_sts_t          sts_o,
  output out_rsp_t         out_rsp_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic [PTR_W-1:0]  wr_pos_q, wr_pos_d;
  logic [PTR_W-1:0]  rd_pos_q, rd_pos_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [LEN_W-1:0]  pending_q, pending_d;
  logic [LEN_W-1:0]  total_q, total_d;
  logic [LEN_W-1:0]  rd_left_q, rd_left_d;
  logic [LEN_W-1:0]  rd_done_q, rd_done_d;
  logic [CNT_W-1:0]  cap_q;
  out_rsp_t          out_q, out_d;

  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  rd_count;
  logic [SUM_W-1:0]  fill_sum;
  logic              mem_we;

  // Read burst length: clamp to the burst limit, then to the fill.
  assign len_clamp = (in_req_i.burst_length > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                                  : in_req_i.burst_length;
  assign rd_count  = (CNT_W'(len_clamp) > fill_q) ? fill_q[LEN_W-1:0] : len_clamp;
  assign fill_sum  = SUM_W'(fill_q) + SUM_W'(total_q);
  assign mem_we    = (cmd_i.op == OP_DATA_WR);

  // State update and the result that goes with it.
  always_comb begin
    wr_pos_d  = wr_pos_q;
    rd_pos_d  = rd_pos_q;
    fill_d    = fill_q;
    pending_d = pending_q;
    total_d   = total_q;
    rd_left_d = rd_left_q;
    rd_done_d = rd_done_q;
    out_d     = out_q;
    out_d.status     = STS_OK;
    out_d.read_byte  = '0;
    out_d.bytes_done = '0;
    out_d.last       = 1'b1;
    case (cmd_i.op)
      OP_HDR_OK: begin
        pending_d        = in_req_i.burst_length;
        total_d          = in_req_i.burst_length;
        out_d.bytes_done = in_req_i.burst_length;
      end
      OP_REJECT: begin
        out_d.status = STS_REJECT;
      end
      OP_SEQ_ERR: begin
        out_d.status = STS_SEQ_ERR;
      end
      OP_DATA_WR: begin
        wr_pos_d  = next_pos(wr_pos_q, cap_q);
        pending_d = pending_q - LEN_W'(1);
        // The whole burst becomes visible once its last byte lands.
        if (pending_d == '0) begin
          fill_d = (fill_sum > SUM_W'(DEPTH)) ? CNT_W'(DEPTH) : fill_sum[CNT_W-1:0];
        end
        out_d.bytes_done = total_q - pending_d;
      end
      OP_RD_START: begin
        fill_d    = fill_q - CNT_W'(rd_count);
        rd_left_d = rd_count;
        rd_done_d = '0;
      end
      OP_RD_BYTE: begin
        rd_pos_d         = next_pos(rd_pos_q, cap_q);
        rd_left_d        = rd_left_q - LEN_W'(1);
        rd_done_d        = rd_done_q + LEN_W'(1);
        out_d.read_byte  = rdata_q;
        out_d.bytes_done = rd_done_d;
        out_d.last       = (rd_left_q == LEN_W'(1));
      end
      OP_CLEAR: begin
        wr_pos_d  = '0;
        rd_pos_d  = '0;
        fill_d    = '0;
        pending_d = '0;
        total_d   = '0;
      end
      default: begin
      end
    endcase
    out_d.available  = fill_d;
    out_d.free_space = free_of(fill_d, cap_q);
  end

  // Byte store; the read port follows the next read position so that the
  // registered data always belongs to the current one.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_pos_q] <= in_req_i.data_byte;
    end
    rdata_q <= mem[rd_pos_d];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  // Positions, counts and the capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q  <= '0;
      rd_pos_q  <= '0;
      fill_q    <= '0;
      pending_q <= '0;
      total_q   <= '0;
      rd_left_q <= '0;
      rd_done_q <= '0;
      cap_q     <= CNT_W'(DEPTH);
    end else begin
      wr_pos_q  <= wr_pos_d;
      rd_pos_q  <= rd_pos_d;
      fill_q    <= fill_d;
      pending_q <= pending_d;
      total_q   <= total_d;
      rd_left_q <= rd_left_d;
      rd_done_q <= rd_done_d;
      if (cfg_we_i) begin
        cap_q <= clamp_cap(cfg_wdata_i);
      end
    end
  end

  assign sts_o.pending_zero = (pending_q == '0);
  assign sts_o.fill_zero    = (fill_q == '0);
  assign sts_o.free_space   = free_of(fill_q, cap_q);
  assign sts_o.rd_last      = (rd_left_q == LEN_W'(1));
  assign cap_o              = cap_q;
  assign out_rsp_o          = out_q;

endmodule
